[hw/rtl/irtx_pkg.sv]
// Shared types, constants and helper functions of the infrared frame transmitter.
`default_nettype none
package irtx_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned TIME_W      = 17;
  localparam int unsigned SHORT_W     = 16;

  localparam logic [2:0] REG_MARK         = 3'd0;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd1;
  localparam logic [2:0] REG_LEADER_MARK  = 3'd2;
  localparam logic [2:0] REG_LEADER_SPACE = 3'd3;
  localparam logic [2:0] REG_REPEAT_SPACE = 3'd4;
  localparam logic [2:0] REG_FRAME_GAP    = 3'd5;
  localparam logic [2:0] REG_REPEAT_GAP   = 3'd6;

  localparam logic [SHORT_W-1:0] MARK_RST         = 16'd561;
  localparam logic [SHORT_W-1:0] ONE_SPACE_RST    = 16'd1686;
  localparam logic [SHORT_W-1:0] LEADER_MARK_RST  = 16'd8999;
  localparam logic [SHORT_W-1:0] LEADER_SPACE_RST = 16'd4490;
  localparam logic [SHORT_W-1:0] REPEAT_SPACE_RST = 16'd2250;
  localparam logic [TIME_W-1:0]  FRAME_GAP_RST    = 17'd40000;
  localparam logic [TIME_W-1:0]  REPEAT_GAP_RST   = 17'd96187;

  localparam logic [5:0] FRAME_BITS = 6'd32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_FRAME  = 2'd1,
    OP_REPEAT = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LMARK  = 4'd1,
    PH_LSPACE = 4'd2,
    PH_BMARK  = 4'd3,
    PH_BSPACE = 4'd4,
    PH_SMARK  = 4'd5,
    PH_FGAP   = 4'd6,
    PH_RLMARK = 4'd7,
    PH_RSPACE = 4'd8,
    PH_RBMARK = 4'd9,
    PH_RGAP   = 4'd10
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] address;
    logic [7:0] command;
  } item_t;

  typedef struct packed {
    logic [SHORT_W-1:0] mark_time;
    logic [SHORT_W-1:0] one_space_time;
    logic [SHORT_W-1:0] leader_mark_time;
    logic [SHORT_W-1:0] leader_space_time;
    logic [SHORT_W-1:0] repeat_space_time;
    logic [TIME_W-1:0]  frame_gap_time;
    logic [TIME_W-1:0]  repeat_gap_time;
  } cfg_t;

  // An interval programmed as zero still lasts one tick.
  function automatic logic [TIME_W-1:0] dur_fix(input logic [TIME_W-1:0] d);
    logic [TIME_W-1:0] r;
    r = (d == '0) ? TIME_W'(1) : d;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] widen(input logic [SHORT_W-1:0] d);
    logic [TIME_W-1:0] r;
    r = {{(TIME_W - SHORT_W){1'b0}}, d};
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/irtx_front.sv]
// Front end: decodes incoming words and holds them in a small in-order queue.
`default_nettype none
module irtx_front #(
  parameter int unsigned Depth = irtx_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [1:0]     cmd_i,
  input  wire logic [7:0]     address_i,
  input  wire logic [7:0]     command_i,
  output logic                q_valid_o,
  output irtx_pkg::item_t     q_item_o,
  input  wire logic           q_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  irtx_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  irtx_pkg::item_t   item_in;
  logic              push, pop;

  always_comb begin
    unique case (cmd_i)
      irtx_pkg::OP_TICK:   item_in.op = irtx_pkg::OP_TICK;
      irtx_pkg::OP_FRAME:  item_in.op = irtx_pkg::OP_FRAME;
      irtx_pkg::OP_REPEAT: item_in.op = irtx_pkg::OP_REPEAT;
      default:             item_in.op = irtx_pkg::OP_NOP;
    endcase
    item_in.address = address_i;
    item_in.command = command_i;
  end

  assign in_stall_o = (count_q == CntW'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

endmodule
`default_nettype wire

[hw/rtl/irtx_back.sv]
// Back end: frame sequencer that executes queued words and registers one result each.
`default_nettype none
module irtx_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire irtx_pkg::cfg_t  cfg_i,
  input  wire logic            q_valid_i,
  input  wire irtx_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 carrier_on_o,
  output logic                 busy_res_o,
  output logic                 accepted_o,
  output logic                 finished_o
);

  localparam int unsigned TW = irtx_pkg::TIME_W;

  irtx_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]    time_left_q, time_left_d;
  logic [5:0]       bits_left_q, bits_left_d;
  logic [31:0]      payload_q, payload_d;

  logic             out_valid_q;
  logic             carrier_q, busy_q, accepted_q, finished_q;
  logic             res_carrier, res_busy, res_accepted, res_finished;

  logic             running, is_tick, is_start, expire;
  logic [TW-1:0]    tl_dec;
  logic [5:0]       bits_dec;

  assign q_pop_o  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign running  = (phase_q != irtx_pkg::PH_IDLE);
  assign is_tick  = (q_item_i.op == irtx_pkg::OP_TICK);
  assign is_start = (q_item_i.op == irtx_pkg::OP_FRAME) ||
                    (q_item_i.op == irtx_pkg::OP_REPEAT);
  assign tl_dec   = time_left_q - 1'b1;
  assign bits_dec = bits_left_q - 1'b1;
  assign expire   = is_tick && running && (tl_dec == '0);

  // Next state.
  always_comb begin
    phase_d     = phase_q;
    time_left_d = time_left_q;
    bits_left_d = bits_left_q;
    payload_d   = payload_q;
    if (q_pop_o) begin
      if (is_tick && running) begin
        time_left_d = tl_dec;
        if (expire) begin
          unique case (phase_q)
            irtx_pkg::PH_LMARK: begin
              phase_d     = irtx_pkg::PH_LSPACE;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.leader_space_time));
            end
            irtx_pkg::PH_LSPACE: begin
              phase_d     = irtx_pkg::PH_BMARK;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.mark_time));
            end
            irtx_pkg::PH_BMARK: begin
              phase_d     = irtx_pkg::PH_BSPACE;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(
                payload_q[31] ? cfg_i.one_space_time : cfg_i.mark_time));
            end
            irtx_pkg::PH_BSPACE: begin
              payload_d   = {payload_q[30:0], 1'b0};
              bits_left_d = bits_dec;
              phase_d     = (bits_dec == '0) ? irtx_pkg::PH_SMARK : irtx_pkg::PH_BMARK;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.mark_time));
            end
            irtx_pkg::PH_SMARK: begin
              phase_d     = irtx_pkg::PH_FGAP;
              time_left_d = irtx_pkg::dur_fix(cfg_i.frame_gap_time);
            end
            irtx_pkg::PH_RLMARK: begin
              phase_d     = irtx_pkg::PH_RSPACE;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.repeat_space_time));
            end
            irtx_pkg::PH_RSPACE: begin
              phase_d     = irtx_pkg::PH_RBMARK;
              time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.mark_time));
            end
            irtx_pkg::PH_RBMARK: begin
              phase_d     = irtx_pkg::PH_RGAP;
              time_left_d = irtx_pkg::dur_fix(cfg_i.repeat_gap_time);
            end
            default: begin
              phase_d     = irtx_pkg::PH_IDLE;
              time_left_d = '0;
            end
          endcase
        end
      end else if (is_start && !running) begin
        time_left_d = irtx_pkg::dur_fix(irtx_pkg::widen(cfg_i.leader_mark_time));
        if (q_item_i.op == irtx_pkg::OP_FRAME) begin
          phase_d     = irtx_pkg::PH_LMARK;
          bits_left_d = irtx_pkg::FRAME_BITS;
          payload_d   = {q_item_i.address, ~q_item_i.address,
                         q_item_i.command, ~q_item_i.command};
        end else begin
          phase_d = irtx_pkg::PH_RLMARK;
        end
      end
    end
  end

  // Result of the word being executed.
  always_comb begin
    res_carrier  = 1'b0;
    res_busy     = running;
    res_accepted = 1'b0;
    res_finished = 1'b0;
    unique case (q_item_i.op)
      irtx_pkg::OP_TICK: begin
        res_carrier  = (phase_q == irtx_pkg::PH_LMARK)  || (phase_q == irtx_pkg::PH_BMARK) ||
                       (phase_q == irtx_pkg::PH_SMARK)  || (phase_q == irtx_pkg::PH_RLMARK) ||
                       (phase_q == irtx_pkg::PH_RBMARK);
        res_finished = expire && ((phase_q == irtx_pkg::PH_FGAP) ||
                                  (phase_q == irtx_pkg::PH_RGAP) ||
                                  (phase_q == irtx_pkg::PH_IDLE));
      end
      irtx_pkg::OP_FRAME, irtx_pkg::OP_REPEAT: begin
        res_busy     = 1'b1;
        res_accepted = !running;
      end
      default: begin
        res_busy = running;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= irtx_pkg::PH_IDLE;
      time_left_q <= '0;
      bits_left_q <= '0;
      payload_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      time_left_q <= time_left_d;
      bits_left_q <= bits_left_d;
      payload_q   <= payload_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      carrier_q  <= res_carrier;
      busy_q     <= res_busy;
      accepted_q <= res_accepted;
      finished_q <= res_finished;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign carrier_on_o = carrier_q;
  assign busy_res_o   = busy_q;
  assign accepted_o   = accepted_q;
  assign finished_o   = finished_q;

  a_time_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != irtx_pkg::PH_IDLE) |-> (time_left_q != '0))
    else $error("running phase with no time left");

  a_bits_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == irtx_pkg::PH_BMARK) || (phase_q == irtx_pkg::PH_BSPACE))
      |-> (bits_left_q != '0))
    else $error("data phase with no bits left");

  a_carrier_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && carrier_q) |-> busy_q)
    else $error("carrier reported while not busy");

  a_fin_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && finished_q) |-> !accepted_q)
    else $error("finish and accept in one result");

endmodule
`default_nettype wire

[hw/rtl/ir_remote_frame_transmitter_core.sv]
// Top level of the infrared frame transmitter: register file and front/back instances.
//
//  Channel | Direction | Handshake             | Word
//  in      | input     | in_valid_i/in_stall_o | cmd_i, address_i, command_i
//  out     | output    | out_valid_o/out_stall_i | carrier_on_o, busy_res_o, accepted_o, finished_o
//  cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// The sequencer executes words back to back unless the output stalls with a result held.
// From input to result a word passes the decode queue, then the result register.
// The queue holds QueueDepth words, so with a QueueDepth of at least two the input stalls only after an output stall.
// Reset clears the queue, the sequencer and the result valid and restores register defaults.
`default_nettype none
module ir_remote_frame_transmitter_core #(
  parameter int unsigned QueueDepth = irtx_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [7:0]                    address_i,
  input  wire logic [7:0]                    command_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               carrier_on_o,
  output logic                               busy_res_o,
  output logic                               accepted_o,
  output logic                               finished_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [irtx_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [irtx_pkg::PDATA_W-1:0]  pwdata,
  output logic [irtx_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  irtx_pkg::cfg_t   cfg_q;
  irtx_pkg::item_t  q_item;
  logic             q_valid, q_pop, wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_time         <= irtx_pkg::MARK_RST;
      cfg_q.one_space_time    <= irtx_pkg::ONE_SPACE_RST;
      cfg_q.leader_mark_time  <= irtx_pkg::LEADER_MARK_RST;
      cfg_q.leader_space_time <= irtx_pkg::LEADER_SPACE_RST;
      cfg_q.repeat_space_time <= irtx_pkg::REPEAT_SPACE_RST;
      cfg_q.frame_gap_time    <= irtx_pkg::FRAME_GAP_RST;
      cfg_q.repeat_gap_time   <= irtx_pkg::REPEAT_GAP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        irtx_pkg::REG_MARK:         cfg_q.mark_time         <= pwdata[15:0];
        irtx_pkg::REG_ONE_SPACE:    cfg_q.one_space_time    <= pwdata[15:0];
        irtx_pkg::REG_LEADER_MARK:  cfg_q.leader_mark_time  <= pwdata[15:0];
        irtx_pkg::REG_LEADER_SPACE: cfg_q.leader_space_time <= pwdata[15:0];
        irtx_pkg::REG_REPEAT_SPACE: cfg_q.repeat_space_time <= pwdata[15:0];
        irtx_pkg::REG_FRAME_GAP:    cfg_q.frame_gap_time    <= pwdata[16:0];
        irtx_pkg::REG_REPEAT_GAP:   cfg_q.repeat_gap_time   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      irtx_pkg::REG_MARK:         prdata = {16'd0, cfg_q.mark_time};
      irtx_pkg::REG_ONE_SPACE:    prdata = {16'd0, cfg_q.one_space_time};
      irtx_pkg::REG_LEADER_MARK:  prdata = {16'd0, cfg_q.leader_mark_time};
      irtx_pkg::REG_LEADER_SPACE: prdata = {16'd0, cfg_q.leader_space_time};
      irtx_pkg::REG_REPEAT_SPACE: prdata = {16'd0, cfg_q.repeat_space_time};
      irtx_pkg::REG_FRAME_GAP:    prdata = {15'd0, cfg_q.frame_gap_time};
      irtx_pkg::REG_REPEAT_GAP:   prdata = {15'd0, cfg_q.repeat_gap_time};
      default:                    prdata = '0;
    endcase
  end

  irtx_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cmd_i     (cmd_i),
    .address_i (address_i),
    .command_i (command_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  irtx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .carrier_on_o(carrier_on_o),
    .busy_res_o  (busy_res_o),
    .accepted_o  (accepted_o),
    .finished_o  (finished_o)
  );

endmodule
`default_nettype wire
